// ===== src/rbq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rotation basis to quaternion unit.
package rbq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int FIELD_W       = 16;
    localparam int QS_W          = 17;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    typedef struct packed {
        logic signed [FIELD_W-1:0] w;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic                      zero;
    } t_result;

endpackage

// ===== src/rbq_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one rotation basis per beat.
interface rbq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] rgt_x;
    logic signed [15:0] rgt_y;
    logic signed [15:0] rgt_z;
    logic signed [15:0] upv_x;
    logic signed [15:0] upv_y;
    logic signed [15:0] upv_z;

    modport source (output valid, fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z,
                    upv_x, upv_y, upv_z, input ready);
    modport sink   (input valid, fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z,
                    upv_x, upv_y, upv_z, output ready);
endinterface

// ===== src/rbq_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one quaternion per beat.
interface rbq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               zero_vector;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, zero_vector,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, zero_vector,
                    output ready);
endinterface

// ===== src/rbq_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module rbq_isqrt #(
    parameter int IN_W   = 48,
    parameter int SIDE_W = 1,
    localparam int OUT_W = (IN_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_val,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int PAD = 2 * OUT_W;
    localparam int RW  = OUT_W + 3;

    logic              r_v    [OUT_W];
    logic [RW-1:0]     r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [PAD-1:0]    r_val  [OUT_W];
    logic [SIDE_W-1:0] r_side [OUT_W];

    for (genvar s = 0; s < OUT_W; s++) begin : g_st
        logic              a_v;
        logic [RW-1:0]     a_rem;
        logic [OUT_W-1:0]  a_root;
        logic [PAD-1:0]    a_val;
        logic [SIDE_W-1:0] a_side;
        logic [RW-1:0]     rem2;
        logic [RW-1:0]     trial;
        logic              take;

        if (s == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_val  = PAD'(i_val);
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_v[s-1];
            assign a_rem  = r_rem[s-1];
            assign a_root = r_root[s-1];
            assign a_val  = r_val[s-1];
            assign a_side = r_side[s-1];
        end

        // bring down the next bit pair, try (root*4 + 1)
        assign rem2  = {a_rem[RW-3:0], a_val[PAD-1:PAD-2]};
        assign trial = {1'b0, a_root, 2'b01};
        assign take  = (rem2 >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= take ? (rem2 - trial) : rem2;
                r_root[s] <= {a_root[OUT_W-2:0], take};
                r_val[s]  <= a_val << 2;
                r_side[s] <= a_side;
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];
endmodule

// ===== src/rbq_div.sv =====
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, lanes share one divisor.
module rbq_div #(
    parameter int LANES  = 3,
    parameter int N_W    = 40,
    parameter int D_W    = 24,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][N_W-1:0]   i_num,
    input  logic [D_W-1:0]              i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo,
    output logic [LANES-1:0]            o_ovf,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int W = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

    logic                      r_v    [Q_W];
    logic [LANES-1:0][W-1:0]   r_rem  [Q_W];
    logic [LANES-1:0][Q_W-1:0] r_q    [Q_W];
    logic [LANES-1:0]          r_ovf  [Q_W];
    logic [D_W-1:0]            r_d    [Q_W];
    logic [SIDE_W-1:0]         r_side [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_st
        localparam int B = Q_W - 1 - s;
        logic                      a_v;
        logic [LANES-1:0][W-1:0]   a_rem;
        logic [LANES-1:0][Q_W-1:0] a_q;
        logic [LANES-1:0]          a_ovf;
        logic [D_W-1:0]            a_d;
        logic [SIDE_W-1:0]         a_side;
        logic [W-1:0]              trial;
        logic [LANES-1:0][W-1:0]   n_rem;
        logic [LANES-1:0][Q_W-1:0] n_q;

        if (s == 0) begin : g_first
            always_comb begin
                a_v    = i_valid;
                a_d    = i_den;
                a_side = i_side;
                a_q    = '0;
                for (int l = 0; l < LANES; l++) begin
                    a_rem[l] = W'(i_num[l]);
                    // quotient would not fit in Q_W bits
                    a_ovf[l] = (W'(i_num[l]) >= (W'(i_den) << Q_W));
                end
            end
        end else begin : g_next
            always_comb begin
                a_v    = r_v[s-1];
                a_d    = r_d[s-1];
                a_side = r_side[s-1];
                a_q    = r_q[s-1];
                a_rem  = r_rem[s-1];
                a_ovf  = r_ovf[s-1];
            end
        end

        assign trial = W'(a_d) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (a_rem[l] >= trial) begin
                    n_rem[l] = a_rem[l] - trial;
                    n_q[l]   = {a_q[l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = a_rem[l];
                    n_q[l]   = {a_q[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_ovf[s]  <= a_ovf;
                r_d[s]    <= a_d;
                r_side[s] <= a_side;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_q[Q_W-1];
    assign o_ovf   = r_ovf[Q_W-1];
    assign o_side  = r_side[Q_W-1];
endmodule

// ===== src/rotation_basis_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
// Components are Q1.14 at the default FRAC_BITS. Throughput: one basis per cycle
// while ready is high; the path is a fixed pipeline of square, root and divide
// stages that all advance together on one enable.
// An output register plus a one-entry skid decouple the sides; ready drops only
// while the skid holds a beat. Synchronous active-low reset clears valid bits.
module rotation_basis_to_quaternion_unit #(
    parameter int FRAC_BITS = rbq_pkg::FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rbq_in_if.sink   i_in,
    rbq_out_if.source o_out
);
    import rbq_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int E      = F + 2;          // normalized component, signed
    localparam int NN_W   = F + 24;         // normalize numerator
    localparam int NQ_W   = F + 2;          // normalize quotient
    localparam int L_W    = 24;             // vector length root
    localparam int A_W    = F + 4;          // trace and root arguments
    localparam int P_W    = F + 3;          // quaternion numerators
    localparam int S2_IN  = 2 * F + 3;
    localparam int S2_OUT = (S2_IN + 1) / 2;
    localparam int FN_W   = 2 * F + 3;
    localparam int FD_W   = S2_OUT + 1;
    localparam int H_W    = S2_OUT;
    localparam int HX     = ((H_W > 16) ? H_W : 16) + 1;
    localparam int SIDE1  = 49;
    localparam int SIDE2  = 3 + 3 * P_W;
    localparam int SIDE3  = 1 + 2 + 3 + 1 + H_W;

    localparam logic [NQ_W-1:0]       ONE_Q = {2'b01, {F{1'b0}}};
    localparam logic signed [A_W-1:0] ONE_A = {4'b0001, {F{1'b0}}};

    // numerator slots of the trace stage
    localparam int PI_UF = 0;   // u.z - f.y
    localparam int PI_FR = 1;   // f.x - r.z
    localparam int PI_RU = 2;   // r.y - u.x
    localparam int PI_UR = 3;   // u.x + r.y
    localparam int PI_FS = 4;   // f.x + r.z
    localparam int PI_FU = 5;   // f.y + u.z

    function automatic logic [15:0] abs16(input logic signed [15:0] a);
        logic signed [16:0] e;
        e = 17'(a);
        return a[15] ? 16'(-e) : 16'(e);
    endfunction

    function automatic logic [P_W-1:0] absp(input logic signed [P_W-1:0] a);
        return a[P_W-1] ? P_W'(-a) : P_W'(a);
    endfunction

    function automatic logic signed [15:0] sat_lane(input logic neg, input logic ovf,
                                                    input logic [QS_W-1:0] q);
        if (!neg) begin
            return (ovf || q > 17'd32767) ? $signed(16'h7FFF) : $signed(16'(q));
        end
        return (ovf || q > 17'd32768) ? $signed(16'h8000) : $signed(16'(-q));
    endfunction

    logic en;

    // ---- stage 1: input capture --------------------------------------------
    logic               r1_v;
    logic signed [15:0] r1_c [9];

    // ---- stage 2: squares --------------------------------------------------
    logic               r2_v;
    logic signed [15:0] r2_c [9];
    logic [31:0]        r2_sq [9];

    // ---- stage 3: squared lengths ------------------------------------------
    logic               r3_v;
    logic signed [15:0] r3_c [9];
    logic [31:0]        r3_len [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] p;
        if (en) begin
            r1_c[0] <= i_in.fwd_x;
            r1_c[1] <= i_in.fwd_y;
            r1_c[2] <= i_in.fwd_z;
            r1_c[3] <= i_in.rgt_x;
            r1_c[4] <= i_in.rgt_y;
            r1_c[5] <= i_in.rgt_z;
            r1_c[6] <= i_in.upv_x;
            r1_c[7] <= i_in.upv_y;
            r1_c[8] <= i_in.upv_z;
            for (int i = 0; i < 9; i++) begin
                p        = 32'(r1_c[i]) * 32'(r1_c[i]);
                r2_sq[i] <= 32'(p);
                r2_c[i]  <= r1_c[i];
                r3_c[i]  <= r2_c[i];
            end
            for (int v = 0; v < 3; v++) begin
                r3_len[v] <= r2_sq[3*v] + r2_sq[3*v+1] + r2_sq[3*v+2];
            end
        end
    end

    // ---- normalization: length root, then divide --------------------------
    logic                       n1_v    [3];
    logic [L_W-1:0]             n1_l    [3];
    logic [SIDE1-1:0]           n1_side [3];
    logic                       r4_v    [3];
    logic [2:0][NN_W-1:0]       r4_num  [3];
    logic [L_W-1:0]             r4_den  [3];
    logic [3:0]                 r4_side [3];
    logic                       d1_v    [3];
    logic [2:0][NQ_W-1:0]       d1_q    [3];
    logic [2:0]                 d1_ovf  [3];
    logic [3:0]                 d1_side [3];

    for (genvar v = 0; v < 3; v++) begin : g_vec
        rbq_isqrt #(
            .IN_W   (48),
            .SIDE_W (SIDE1)
        ) u_len (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r3_v),
            .i_val   ({r3_len[v], 16'h0000}),
            .i_side  ({(r3_len[v] == 32'd0), r3_c[3*v], r3_c[3*v+1], r3_c[3*v+2]}),
            .o_valid (n1_v[v]),
            .o_root  (n1_l[v]),
            .o_side  (n1_side[v])
        );

        // numerator = |c| << (F+8), plus half the divisor for rounding
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r4_v[v] <= 1'b0;
            end else if (en) begin
                r4_v[v] <= n1_v[v];
            end
        end

        always_ff @(posedge i_clk) begin
            logic signed [15:0] c;
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    c = n1_side[v][47-16*k -: 16];
                    r4_num[v][k]  <= (NN_W'(abs16(c)) << (F + 8)) + NN_W'(n1_l[v] >> 1);
                    r4_side[v][k] <= c[15];
                end
                r4_side[v][3] <= n1_side[v][48];
                r4_den[v]     <= n1_l[v];
            end
        end

        rbq_div #(
            .LANES  (3),
            .N_W    (NN_W),
            .D_W    (L_W),
            .Q_W    (NQ_W),
            .SIDE_W (4)
        ) u_ndiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r4_v[v]),
            .i_num   (r4_num[v]),
            .i_den   (r4_den[v]),
            .i_side  (r4_side[v]),
            .o_valid (d1_v[v]),
            .o_quo   (d1_q[v]),
            .o_ovf   (d1_ovf[v]),
            .o_side  (d1_side[v])
        );
    end

    // ---- stage 5: clamp to [-ONE, ONE] and apply sign ----------------------
    logic                r5_v;
    logic                r5_zero;
    logic signed [E-1:0] r5_n [3][3];     // [vector][component]

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= d1_v[0] & d1_v[1] & d1_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NQ_W-1:0] mag;
        if (en) begin
            r5_zero <= d1_side[0][3] | d1_side[1][3] | d1_side[2][3];
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    mag = (d1_ovf[v][k] || d1_q[v][k] > ONE_Q) ? ONE_Q : d1_q[v][k];
                    r5_n[v][k] <= d1_side[v][k] ? -$signed(mag) : $signed(mag);
                end
            end
        end
    end

    // ---- stage 6: trace, diagonal compares, arguments, numerators ----------
    logic                r6_v;
    logic                r6_zero;
    logic signed [A_W-1:0] r6_tr;
    logic                r6_gt_ru;
    logic                r6_gt_rf;
    logic                r6_gt_uf;
    logic signed [A_W-1:0] r6_arg [4];
    logic signed [P_W-1:0] r6_p   [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [A_W-1:0] rx, uy, fz;
        rx = A_W'(r5_n[1][0]);
        uy = A_W'(r5_n[2][1]);
        fz = A_W'(r5_n[0][2]);
        if (en) begin
            r6_zero   <= r5_zero;
            r6_tr     <= rx + uy + fz;
            r6_gt_ru  <= (r5_n[1][0] > r5_n[2][1]);
            r6_gt_rf  <= (r5_n[1][0] > r5_n[0][2]);
            r6_gt_uf  <= (r5_n[2][1] > r5_n[0][2]);
            r6_arg[BR_W] <= rx + uy + fz + ONE_A;
            r6_arg[BR_X] <= ONE_A + rx - uy - fz;
            r6_arg[BR_Y] <= ONE_A + uy - rx - fz;
            r6_arg[BR_Z] <= ONE_A + fz - rx - uy;
            r6_p[PI_UF] <= P_W'(r5_n[2][2]) - P_W'(r5_n[0][1]);
            r6_p[PI_FR] <= P_W'(r5_n[0][0]) - P_W'(r5_n[1][2]);
            r6_p[PI_RU] <= P_W'(r5_n[1][1]) - P_W'(r5_n[2][0]);
            r6_p[PI_UR] <= P_W'(r5_n[2][0]) + P_W'(r5_n[1][1]);
            r6_p[PI_FS] <= P_W'(r5_n[0][0]) + P_W'(r5_n[1][2]);
            r6_p[PI_FU] <= P_W'(r5_n[0][1]) + P_W'(r5_n[2][2]);
        end
    end

    // ---- stage 7: branch pick, root argument -------------------------------
    t_branch               c7_br;
    logic signed [A_W-1:0] c7_arg;
    logic signed [P_W-1:0] c7_p [3];

    always_comb begin
        if (r6_tr > 0) begin
            c7_br = BR_W;
        end else if (r6_gt_ru && r6_gt_rf) begin
            c7_br = BR_X;
        end else if (r6_gt_uf) begin
            c7_br = BR_Y;
        end else begin
            c7_br = BR_Z;
        end
        c7_arg = r6_arg[c7_br];
        case (c7_br)
            BR_W: begin
                c7_p[0] = r6_p[PI_UF];
                c7_p[1] = r6_p[PI_FR];
                c7_p[2] = r6_p[PI_RU];
            end
            BR_X: begin
                c7_p[0] = r6_p[PI_UF];
                c7_p[1] = r6_p[PI_UR];
                c7_p[2] = r6_p[PI_FS];
            end
            BR_Y: begin
                c7_p[0] = r6_p[PI_FR];
                c7_p[1] = r6_p[PI_UR];
                c7_p[2] = r6_p[PI_FU];
            end
            default: begin
                c7_p[0] = r6_p[PI_RU];
                c7_p[1] = r6_p[PI_FS];
                c7_p[2] = r6_p[PI_FU];
            end
        endcase
    end

    logic             r7_v;
    logic [SIDE2-1:0] r7_side;
    logic [S2_IN-1:0] r7_sqin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // negative argument (non-orthonormal basis) clamps to a zero root
            r7_sqin <= (c7_arg > 0) ? (S2_IN'(c7_arg) << F) : '0;
            r7_side <= {r6_zero, c7_br, c7_p[0], c7_p[1], c7_p[2]};
        end
    end

    // ---- quaternion root ---------------------------------------------------
    logic              s2_v;
    logic [S2_OUT-1:0] s2_root;
    logic [SIDE2-1:0]  s2_side;

    rbq_isqrt #(
        .IN_W   (S2_IN),
        .SIDE_W (SIDE2)
    ) u_qroot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_val   (r7_sqin),
        .i_side  (r7_side),
        .o_valid (s2_v),
        .o_root  (s2_root),
        .o_side  (s2_side)
    );

    // ---- stage 8: divide setup, denominator is 2*sq ------------------------
    logic                 r8_v;
    logic [2:0][FN_W-1:0] r8_num;
    logic [FD_W-1:0]      r8_den;
    logic [SIDE3-1:0]     r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [P_W-1:0] p;
        logic [2:0]            sgn;
        logic [H_W:0]          t;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                p         = s2_side[3*P_W-1-P_W*k -: P_W];
                sgn[2-k]  = p[P_W-1];
                r8_num[k] <= (FN_W'(absp(p)) << F) + FN_W'(s2_root);
            end
            t       = (H_W + 1)'(s2_root) + 1'b1;
            r8_den  <= {s2_root, 1'b0};
            r8_side <= {s2_side[SIDE2-1 -: 3], sgn, (s2_root == '0), t[H_W:1]};
        end
    end

    logic                 d2_v;
    logic [2:0][QS_W-1:0] d2_q;
    logic [2:0]           d2_ovf;
    logic [SIDE3-1:0]     d2_side;

    rbq_div #(
        .LANES  (3),
        .N_W    (FN_W),
        .D_W    (FD_W),
        .Q_W    (QS_W),
        .SIDE_W (SIDE3)
    ) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  (r8_side),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_ovf   (d2_ovf),
        .o_side  (d2_side)
    );

    // ---- stage 9: saturate and place components ----------------------------
    logic               f_zero;
    t_branch            f_br;
    logic [2:0]         f_sgn;
    logic               f_sqz;
    logic [H_W-1:0]     f_half;
    logic signed [15:0] f_h;
    logic signed [15:0] f_l [3];
    t_result            c9_res;

    always_comb begin
        f_zero = d2_side[SIDE3-1];
        f_br   = t_branch'(d2_side[SIDE3-2 -: 2]);
        f_sgn  = d2_side[SIDE3-4 -: 3];
        f_sqz  = d2_side[H_W];
        f_half = d2_side[H_W-1:0];
        f_h    = (HX'(f_half) > HX'(32767)) ? $signed(16'h7FFF) : $signed(16'(f_half));
        for (int k = 0; k < 3; k++) begin
            // zero root means zero divisor: quotient is zero
            f_l[k] = f_sqz ? 16'sd0 : sat_lane(f_sgn[2-k], d2_ovf[k], d2_q[k]);
        end
        c9_res.zero = f_zero;
        case (f_br)
            BR_X: begin
                c9_res.w = f_l[0]; c9_res.x = f_h;    c9_res.y = f_l[1]; c9_res.z = f_l[2];
            end
            BR_Y: begin
                c9_res.w = f_l[0]; c9_res.x = f_l[1]; c9_res.y = f_h;    c9_res.z = f_l[2];
            end
            BR_Z: begin
                c9_res.w = f_l[0]; c9_res.x = f_l[1]; c9_res.y = f_l[2]; c9_res.z = f_h;
            end
            default: begin
                c9_res.w = f_h;    c9_res.x = f_l[0]; c9_res.y = f_l[1]; c9_res.z = f_l[2];
            end
        endcase
        if (f_zero) begin
            c9_res.w = '0;
            c9_res.x = '0;
            c9_res.y = '0;
            c9_res.z = '0;
        end
    end

    logic    rP_v;
    t_result rP_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP_v <= 1'b0;
        end else if (en) begin
            rP_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rP_res <= c9_res;
        end
    end

    // ---- output register and skid ------------------------------------------
    // The pipeline end beat is consumed at every enabled edge; it lands in the
    // output register, or in the skid when the output is stalled.
    logic    r_ov;
    logic    r_sv;
    t_result r_ores;
    t_result r_sres;

    assign en = ~r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (en) begin
            if (rP_v) begin
                if (!r_ov || o_out.ready) begin
                    r_ov <= 1'b1;
                end else begin
                    r_sv <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end else if (o_out.ready) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && rP_v) begin
            if (!r_ov || o_out.ready) begin
                r_ores <= rP_res;
            end else begin
                r_sres <= rP_res;
            end
        end else if (!en && o_out.ready) begin
            r_ores <= r_sres;
        end
    end

    assign i_in.ready        = en;
    assign o_out.valid       = r_ov;
    assign o_out.quat_w      = r_ores.w;
    assign o_out.quat_x      = r_ores.x;
    assign o_out.quat_y      = r_ores.y;
    assign o_out.quat_z      = r_ores.z;
    assign o_out.zero_vector = r_ores.zero;
endmodule

// ===== src/rbq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the rotation basis to quaternion unit, bound to the top.
module rbq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_quat_w,
    input logic [15:0] i_quat_x,
    input logic [15:0] i_quat_y,
    input logic [15:0] i_quat_z,
    input logic        i_zero_vector
);
    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_quat_w, i_quat_x, i_quat_y, i_quat_z, i_zero_vector}))
        else $error("output beat changed while stalled");

    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_vector |->
            (i_quat_w == 16'd0) && (i_quat_x == 16'd0) &&
            (i_quat_y == 16'd0) && (i_quat_z == 16'd0))
        else $error("zero-length basis with nonzero quaternion");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind rotation_basis_to_quaternion_unit rbq_checker u_rbq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_quat_w      (o_out.quat_w),
    .i_quat_x      (o_out.quat_x),
    .i_quat_y      (o_out.quat_y),
    .i_quat_z      (o_out.quat_z),
    .i_zero_vector (o_out.zero_vector)
);
